/* design/thermal_false_color_mapper_core_assert.svh */
// Assertion macros shared by the thermal false-color mapper RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef THERMAL_FALSE_COLOR_MAPPER_CORE_ASSERT_SVH
`define THERMAL_FALSE_COLOR_MAPPER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TFCM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TFCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/tfcm_pkg.sv */
// Shared types and constants of the thermal false-color mapper.
// No dependencies; imported by tfcm_colorize and the top level.
`default_nettype none

package tfcm_pkg;

    // Field widths.
    localparam int TEMP_W  = 16;
    localparam int SCALE_W = 24;
    localparam int POS_W   = 16;
    localparam int OFS_W   = 14;
    localparam int CHAN_W  = 8;
    localparam int CFG_IDX_W = 2;

    // Register reset values: span of -20.00 C to 300.00 C.
    localparam logic signed [TEMP_W-1:0] LOW_TEMP_RST = -16'sd2000;
    localparam logic [SCALE_W-1:0]       SCALE_RST    = 24'd134218;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_TEMP = 2'd0,
        CFG_SCALE    = 2'd1
    } t_cfg_idx;

    // Palette segment starts along the Q0.16 position.
    localparam logic [POS_W-1:0] SEG1_START = 16'd10945;
    localparam logic [POS_W-1:0] SEG2_START = 16'd21823;
    localparam logic [POS_W-1:0] SEG3_START = 16'd32768;
    localparam logic [POS_W-1:0] SEG4_START = 16'd43713;
    localparam logic [POS_W-1:0] SEG5_START = 16'd54591;

    // Ramp gain: 255 steps across one segment, Q0.16.
    localparam logic [10:0] RAMP_GAIN = 11'd1527;

    // Palette segments, cold to hot.
    typedef enum logic [2:0] {
        SEG_BLUE_UP   = 3'd0,
        SEG_GREEN_UP  = 3'd1,
        SEG_BLUE_DN   = 3'd2,
        SEG_RED_UP    = 3'd3,
        SEG_GREEN_DN  = 3'd4,
        SEG_WHITE_UP  = 3'd5
    } t_seg;

endpackage

`default_nettype wire

/* design/tfcm_colorize.sv */
// Palette back end: segment select, ramp multiply and channel mapping.
// Depends on tfcm_pkg and the assertion macro header.
`default_nettype none

module tfcm_colorize (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic [tfcm_pkg::POS_W-1:0]   i_pos,
    output logic                              o_valid,
    output logic [tfcm_pkg::CHAN_W-1:0]       o_red,
    output logic [tfcm_pkg::CHAN_W-1:0]       o_green,
    output logic [tfcm_pkg::CHAN_W-1:0]       o_blue
);
    import tfcm_pkg::*;

    `include "thermal_false_color_mapper_core_assert.svh"

    // Stage A: segment and offset within it.
    logic                 r_a_valid;
    t_seg                 r_a_seg;
    logic [OFS_W-1:0]     r_a_ofs;
    t_seg                 n_a_seg;
    logic [POS_W-1:0]     n_a_start;
    logic [POS_W-1:0]     n_a_diff;

    always_comb begin
        if (i_pos < SEG1_START) begin
            n_a_seg = SEG_BLUE_UP;  n_a_start = '0;
        end else if (i_pos < SEG2_START) begin
            n_a_seg = SEG_GREEN_UP; n_a_start = SEG1_START;
        end else if (i_pos < SEG3_START) begin
            n_a_seg = SEG_BLUE_DN;  n_a_start = SEG2_START;
        end else if (i_pos < SEG4_START) begin
            n_a_seg = SEG_RED_UP;   n_a_start = SEG3_START;
        end else if (i_pos < SEG5_START) begin
            n_a_seg = SEG_GREEN_DN; n_a_start = SEG4_START;
        end else begin
            n_a_seg = SEG_WHITE_UP; n_a_start = SEG5_START;
        end
        n_a_diff = i_pos - n_a_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
        r_a_seg <= n_a_seg;
        r_a_ofs <= n_a_diff[OFS_W-1:0];
    end

    // Stage B: ramp value, clamped to a full byte.
    localparam int PROD_W = OFS_W + 11;
    logic                 r_b_valid;
    t_seg                 r_b_seg;
    logic [CHAN_W-1:0]    r_b_ramp;
    logic [PROD_W-1:0]    n_b_prod;
    logic [CHAN_W-1:0]    n_b_ramp;

    always_comb begin
        n_b_prod = PROD_W'(r_a_ofs) * PROD_W'(RAMP_GAIN);
        n_b_ramp = n_b_prod[PROD_W-1] ? {CHAN_W{1'b1}} : n_b_prod[23:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_seg  <= r_a_seg;
        r_b_ramp <= n_b_ramp;
    end

    // Stage C: channel mapping into the output registers.
    logic [CHAN_W-1:0] n_red, n_green, n_blue;
    logic [CHAN_W-1:0] w_fall;
    localparam logic [CHAN_W-1:0] FULL = {CHAN_W{1'b1}};

    always_comb begin
        w_fall  = FULL - r_b_ramp;
        n_red   = '0;
        n_green = '0;
        n_blue  = '0;
        case (r_b_seg)
            SEG_BLUE_UP: begin
                n_blue = r_b_ramp;
            end
            SEG_GREEN_UP: begin
                n_green = r_b_ramp; n_blue = FULL;
            end
            SEG_BLUE_DN: begin
                n_green = FULL; n_blue = w_fall;
            end
            SEG_RED_UP: begin
                n_red = r_b_ramp; n_green = FULL;
            end
            SEG_GREEN_DN: begin
                n_red = FULL; n_green = w_fall;
            end
            SEG_WHITE_UP: begin
                n_red = FULL; n_green = r_b_ramp; n_blue = r_b_ramp;
            end
            default: begin
                n_red = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_b_valid;
        end
        o_red   <= n_red;
        o_green <= n_green;
        o_blue  <= n_blue;
    end

    // Checks: valid moves stage to stage; offsets stay inside one segment.
    `TFCM_ASSERT_NEXT(a_stage_a_to_b, i_clk, i_rst_n, r_a_valid, r_b_valid)
    `TFCM_ASSERT_NEXT(a_stage_b_to_out, i_clk, i_rst_n, r_b_valid, o_valid)
    `TFCM_ASSERT_IMPL(a_ofs_in_segment, i_clk, i_rst_n, r_a_valid,
                      r_a_ofs <= OFS_W'(10944) || r_a_seg == SEG_BLUE_UP || r_a_seg == SEG_RED_UP)

endmodule

`default_nettype wire

/* design/thermal_false_color_mapper_core.sv */
// Thermal false-color mapper: one sample per clock. o_busy stays low, so a new request
// may enter at every edge. Five register stages: difference, scale multiply with
// clamp, segment select, ramp multiply, channel map.
// Synchronous active-low reset clears the stage valid bits and loads the registers
// with the span -20.00 C to 300.00 C.
`default_nettype none

module thermal_false_color_mapper_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    output logic                                   o_busy,
    input  wire logic signed [tfcm_pkg::TEMP_W-1:0] i_temperature,
    output logic                                   o_valid,
    output logic [tfcm_pkg::CHAN_W-1:0]            o_red,
    output logic [tfcm_pkg::CHAN_W-1:0]            o_green,
    output logic [tfcm_pkg::CHAN_W-1:0]            o_blue,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [tfcm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [tfcm_pkg::SCALE_W-1:0]      i_cfg_data
);
    import tfcm_pkg::*;

    `include "thermal_false_color_mapper_core_assert.svh"

    // The pipeline never stalls.
    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Configuration registers; unknown indexes are ignored.
    logic signed [TEMP_W-1:0] r_low_temp;
    logic [SCALE_W-1:0]       r_scale;
    logic                     w_cfg_wr;

    assign w_cfg_wr = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_temp <= LOW_TEMP_RST;
            r_scale    <= SCALE_RST;
        end else if (w_cfg_wr) begin
            case (i_cfg_index)
                CFG_LOW_TEMP: r_low_temp <= i_cfg_data[TEMP_W-1:0];
                CFG_SCALE:    r_scale    <= i_cfg_data;
                default:      r_scale    <= r_scale;
            endcase
        end
    end

    // Stage 1: signed difference from the cold end.
    logic                     r_s1_valid;
    logic signed [TEMP_W:0]   r_s1_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_start && !o_busy;
        end
        r_s1_diff <= {i_temperature[TEMP_W-1], i_temperature}
                   - {r_low_temp[TEMP_W-1], r_low_temp};
    end

    // Stage 2: scale to a Q0.16 position and clamp at both ends.
    localparam int MUL_W = TEMP_W + SCALE_W;
    logic                 r_s2_valid;
    logic [POS_W-1:0]     r_s2_pos;
    logic [MUL_W-1:0]     n_s2_prod;
    logic [POS_W-1:0]     n_s2_pos;

    always_comb begin
        n_s2_prod = MUL_W'(r_s1_diff[TEMP_W-1:0]) * MUL_W'(r_scale);
        if (r_s1_diff[TEMP_W] || r_s1_diff == '0) begin
            n_s2_pos = '0;
        end else if (|n_s2_prod[MUL_W-1:POS_W+16]) begin
            n_s2_pos = {POS_W{1'b1}};
        end else begin
            n_s2_pos = n_s2_prod[POS_W+15:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_pos <= n_s2_pos;
    end

    // Stages 3 to 5: palette lookup.
    tfcm_colorize u_colorize (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_valid),
        .i_pos   (r_s2_pos),
        .o_valid (o_valid),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

    // Checks: samples at or below the cold end map to position zero, requests
    // advance every cycle, and a low_temp write lands in its register.
    `TFCM_ASSERT_NEXT(a_cold_clamp, i_clk, i_rst_n,
                      r_s1_valid && (r_s1_diff[TEMP_W] || r_s1_diff == '0), r_s2_pos == '0)
    `TFCM_ASSERT_NEXT(a_s1_to_s2, i_clk, i_rst_n, r_s1_valid, r_s2_valid)
    `TFCM_ASSERT_NEXT(a_low_temp_write, i_clk, i_rst_n,
                      w_cfg_wr && i_cfg_index == CFG_LOW_TEMP,
                      r_low_temp == $past(i_cfg_data[TEMP_W-1:0]))

endmodule

`default_nettype wire
